### rtl/core/tte_pkg.sv
// Shared constants for the timer table expiry block.
// Holds the table size, derived index widths and the operation codes.
// Depends on nothing.
`timescale 1ns / 1ps

package tte_pkg;

	// Number of timer slots, 1 to 64.
	localparam int TABLE_ENTRIES = 16;

	localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

	localparam int ID_W  = 32;
	localparam int REM_W = 16;
	localparam int ENTRY_W = ID_W + REM_W;

	localparam logic [1:0] OP_TICK = 2'd0;
	localparam logic [1:0] OP_ADD  = 2'd1;
	localparam logic [1:0] OP_KILL = 2'd2;

	localparam logic KIND_EXPIRED  = 1'b0;
	localparam logic KIND_REJECTED = 1'b1;

endpackage

### rtl/core/tte_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Width and depth are parameters; depends on nothing else.
`timescale 1ns / 1ps

module tte_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                         clk,
	input  logic                                         we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                             wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                             rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### rtl/core/timer_table_expiry.sv
// Top level of the timer table expiry block.
// Uses tte_pkg for sizes and codes and one tte_ram for timer ids and counts.
`timescale 1ns / 1ps

// A table of TABLE_ENTRIES one-shot timers. Each input transfer is a tick,
// an add (id, timeout) or a kill (id). An add of an id already armed is
// dropped; an add into a full table returns one result with kind = 1. A
// timer added with timeout t expires on tick max(t,1) after the add. A tick
// reports every expired timer in ascending id order, last = 1 on the final
// one, and frees those slots. Ids and counts sit in one RAM with a single
// read port, so every operation walks the table one entry per cycle; a tick
// then runs one minimum-id search pass over the table per expired timer,
// and each result is held until the consumer takes it. An unused operation
// code is taken and dropped. in_ready is high only while no operation is in
// progress. There is no clearing pass: the valid bits in flip-flops mark the
// live slots from reset on.
module timer_table_expiry
	import tte_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,

	input  logic             in_valid,
	output logic             in_ready,
	input  logic [1:0]       op,
	input  logic [ID_W-1:0]  timer_id,
	input  logic [REM_W-1:0] timeout,

	output logic             out_valid,
	input  logic             out_ready,
	output logic [ID_W-1:0]  event_id,
	output logic             kind,
	output logic             last
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_SEARCH,
		ST_ADD_FIN,
		ST_EMIT
	} state_t;

	state_t state_q;

	// Latched command
	logic [1:0]       op_q;
	logic [ID_W-1:0]  id_q;
	logic [REM_W-1:0] timeout_q;

	// Per-slot flags
	logic [TABLE_ENTRIES-1:0] valid_q;
	logic [TABLE_ENTRIES-1:0] due_q;
	logic [CNT_W-1:0]         due_cnt_q;

	// Table walk: addr_q issues reads, the _s1 stage sees the RAM data
	logic [IDX_W-1:0] addr_q;
	logic             issue_q;
	logic             rd_v_s1;
	logic [IDX_W-1:0] rd_idx_s1;

	// Add bookkeeping
	logic             dup_q;
	logic             free_found_q;
	logic [IDX_W-1:0] free_idx_q;

	// Minimum-id search
	logic             best_found_q;
	logic [IDX_W-1:0] best_idx_q;
	logic [ID_W-1:0]  best_id_q;

	// RAM ports
	logic               ram_we;
	logic [IDX_W-1:0]   ram_waddr;
	logic [ENTRY_W-1:0] ram_wdata;
	logic [ENTRY_W-1:0] ram_rdata;
	logic [ID_W-1:0]    rd_id;
	logic [REM_W-1:0]   rd_rem;
	logic               rd_live;
	logic               walk_done;

	// Output register
	logic             out_valid_q;
	logic [ID_W-1:0]  event_id_q;
	logic             kind_q;
	logic             last_q;

	assign rd_id     = ram_rdata[ENTRY_W-1:REM_W];
	assign rd_rem    = ram_rdata[REM_W-1:0];
	assign rd_live   = rd_v_s1 & valid_q[rd_idx_s1];
	assign walk_done = rd_v_s1 && (rd_idx_s1 == LAST_IDX);

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign event_id  = event_id_q;
	assign kind      = kind_q;
	assign last      = last_q;

	tte_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_ENTRIES)
	) u_entry_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(addr_q),
		.rdata(ram_rdata)
	);

	// Write back decremented counts during a tick walk; write a new timer at
	// the end of an add.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = rd_idx_s1;
		ram_wdata = {rd_id, rd_rem - REM_W'(1)};
		if (state_q == ST_SCAN && op_q == OP_TICK && rd_live && rd_rem > REM_W'(1)) begin
			ram_we = 1'b1;
		end else if (state_q == ST_ADD_FIN && !dup_q && free_found_q) begin
			ram_we    = 1'b1;
			ram_waddr = free_idx_q;
			ram_wdata = {id_q, timeout_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			op_q         <= OP_TICK;
			id_q         <= '0;
			timeout_q    <= '0;
			valid_q      <= '0;
			due_q        <= '0;
			due_cnt_q    <= '0;
			addr_q       <= '0;
			issue_q      <= 1'b0;
			rd_v_s1      <= 1'b0;
			rd_idx_s1    <= '0;
			dup_q        <= 1'b0;
			free_found_q <= 1'b0;
			free_idx_q   <= '0;
			best_found_q <= 1'b0;
			best_idx_q   <= '0;
			best_id_q    <= '0;
			out_valid_q  <= 1'b0;
			event_id_q   <= '0;
			kind_q       <= KIND_EXPIRED;
			last_q       <= 1'b0;
		end else begin
			// Advance the table walk whenever a pass is running.
			rd_v_s1   <= issue_q;
			rd_idx_s1 <= addr_q;
			if (issue_q) begin
				if (addr_q == LAST_IDX) begin
					issue_q <= 1'b0;
				end else begin
					addr_q <= addr_q + IDX_W'(1);
				end
			end

			case (state_q)
				ST_IDLE: begin
					if (in_valid && op inside {OP_TICK, OP_ADD, OP_KILL}) begin
						op_q         <= op;
						id_q         <= timer_id;
						timeout_q    <= timeout;
						addr_q       <= '0;
						issue_q      <= 1'b1;
						dup_q        <= 1'b0;
						free_found_q <= 1'b0;
						state_q      <= ST_SCAN;
					end
				end

				ST_SCAN: begin
					if (rd_v_s1) begin
						case (op_q)
							OP_TICK: begin
								// Mark expiring slots; the write-back handles the rest.
								if (rd_live && rd_rem <= REM_W'(1)) begin
									due_q[rd_idx_s1] <= 1'b1;
									due_cnt_q        <= due_cnt_q + CNT_W'(1);
								end
							end
							OP_ADD: begin
								if (rd_live && rd_id == id_q) begin
									dup_q <= 1'b1;
								end
								if (!valid_q[rd_idx_s1] && !free_found_q) begin
									free_found_q <= 1'b1;
									free_idx_q   <= rd_idx_s1;
								end
							end
							OP_KILL: begin
								if (rd_live && rd_id == id_q) begin
									valid_q[rd_idx_s1] <= 1'b0;
								end
							end
							default: begin
							end
						endcase
					end
					if (walk_done) begin
						case (op_q)
							OP_ADD: begin
								state_q <= ST_ADD_FIN;
							end
							OP_TICK: begin
								// The count does not yet include the last entry's update
								// when it is due; check both.
								if (due_cnt_q != '0 ||
								    (rd_live && rd_rem <= REM_W'(1))) begin
									addr_q       <= '0;
									issue_q      <= 1'b1;
									best_found_q <= 1'b0;
									state_q      <= ST_SEARCH;
								end else begin
									state_q <= ST_IDLE;
								end
							end
							default: begin
								state_q <= ST_IDLE;
							end
						endcase
					end
				end

				ST_SEARCH: begin
					// Keep the smallest id among the due slots.
					if (rd_v_s1 && due_q[rd_idx_s1] &&
					    (!best_found_q || rd_id < best_id_q)) begin
						best_found_q <= 1'b1;
						best_idx_q   <= rd_idx_s1;
						best_id_q    <= rd_id;
					end
					if (walk_done) begin
						out_valid_q <= 1'b1;
						kind_q      <= KIND_EXPIRED;
						last_q      <= (due_cnt_q == CNT_W'(1));
						due_cnt_q   <= due_cnt_q - CNT_W'(1);
						if (due_q[rd_idx_s1] && (!best_found_q || rd_id < best_id_q)) begin
							event_id_q           <= rd_id;
							valid_q[rd_idx_s1]   <= 1'b0;
							due_q[rd_idx_s1]     <= 1'b0;
						end else begin
							event_id_q           <= best_id_q;
							valid_q[best_idx_q]  <= 1'b0;
							due_q[best_idx_q]    <= 1'b0;
						end
						state_q <= ST_EMIT;
					end
				end

				ST_ADD_FIN: begin
					if (dup_q) begin
						state_q <= ST_IDLE;
					end else if (free_found_q) begin
						valid_q[free_idx_q] <= 1'b1;
						state_q             <= ST_IDLE;
					end else begin
						out_valid_q <= 1'b1;
						event_id_q  <= id_q;
						kind_q      <= KIND_REJECTED;
						last_q      <= 1'b1;
						state_q     <= ST_EMIT;
					end
				end

				ST_EMIT: begin
					// Hold the result until the consumer takes the transfer.
					if (out_ready) begin
						out_valid_q <= 1'b0;
						if (due_cnt_q != '0) begin
							addr_q       <= '0;
							issue_q      <= 1'b1;
							best_found_q <= 1'b0;
							state_q      <= ST_SEARCH;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

### tb/tte_event_checker.sv
// Event checker for the timer table expiry block: watches both channels,
// keeps its own copy of the timer table and compares every result transfer.
// Depends on tte_pkg for sizes, operation codes and result kinds.
`timescale 1ns / 1ps

module tte_event_checker
	import tte_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,

	input  logic             in_valid,
	input  logic             in_ready,
	input  logic [1:0]       op,
	input  logic [ID_W-1:0]  timer_id,
	input  logic [REM_W-1:0] timeout,

	input  logic             out_valid,
	input  logic             out_ready,
	input  logic [ID_W-1:0]  event_id,
	input  logic             kind,
	input  logic             last,

	output int               mismatch_count,
	output int               events_outstanding
);

	typedef struct packed {
		logic [ID_W-1:0] id;
		logic            kind;
		logic            last;
	} timer_event_t;

	timer_event_t    expected_events [$];
	logic            slot_armed [TABLE_ENTRIES];
	logic [ID_W-1:0] slot_id    [TABLE_ENTRIES];
	logic [REM_W-1:0] slot_left [TABLE_ENTRIES];

	function automatic int find_armed(logic [ID_W-1:0] id);
		for (int i = 0; i < TABLE_ENTRIES; i++)
			if (slot_armed[i] && slot_id[i] == id)
				return i;
		return -1;
	endfunction

	// Update the table copy for one input transfer and queue what it reports.
	task automatic apply_timer_op(input logic [1:0] code, input logic [ID_W-1:0] id,
			input logic [REM_W-1:0] ticks);
		int due [$];
		int slot;
		int best;
		int tmp;
		timer_event_t ev;
		case (code)
			OP_TICK: begin
				for (int i = 0; i < TABLE_ENTRIES; i++) begin
					if (!slot_armed[i])
						continue;
					if (slot_left[i] <= 1) begin
						slot_left[i] = '0;
						due.push_back(i);
					end else begin
						slot_left[i] = slot_left[i] - 1'b1;
					end
				end
				for (int i = 0; i < due.size(); i++) begin
					best = i;
					for (int j = i + 1; j < due.size(); j++)
						if (slot_id[due[j]] < slot_id[due[best]])
							best = j;
					tmp = due[i];
					due[i] = due[best];
					due[best] = tmp;
				end
				for (int k = 0; k < due.size(); k++) begin
					ev.id   = slot_id[due[k]];
					ev.kind = KIND_EXPIRED;
					ev.last = (k == due.size() - 1);
					expected_events.push_back(ev);
					slot_armed[due[k]] = 1'b0;
				end
			end
			OP_ADD: begin
				if (find_armed(id) < 0) begin
					slot = -1;
					for (int i = TABLE_ENTRIES - 1; i >= 0; i--)
						if (!slot_armed[i])
							slot = i;
					if (slot < 0) begin
						ev.id   = id;
						ev.kind = KIND_REJECTED;
						ev.last = 1'b1;
						expected_events.push_back(ev);
					end else begin
						slot_armed[slot] = 1'b1;
						slot_id[slot]    = id;
						slot_left[slot]  = ticks;
					end
				end
			end
			OP_KILL: begin
				slot = find_armed(id);
				if (slot >= 0)
					slot_armed[slot] = 1'b0;
			end
			default: ;
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		timer_event_t ev;
		int errs;
		if (!arst_n) begin
			for (int i = 0; i < TABLE_ENTRIES; i++)
				slot_armed[i] = 1'b0;
			expected_events.delete();
			mismatch_count     <= 0;
			events_outstanding <= 0;
		end else begin
			errs = 0;
			// Results at this edge belong to earlier inputs: compare first.
			if (out_valid && out_ready) begin
				if (expected_events.size() == 0) begin
					$error("unexpected result: event_id %h kind %b last %b",
						event_id, kind, last);
					errs++;
				end else begin
					ev = expected_events.pop_front();
					if (event_id !== ev.id) begin
						$error("event_id: expected %h, got %h", ev.id, event_id);
						errs++;
					end
					if (kind !== ev.kind) begin
						$error("kind: expected %b, got %b", ev.kind, kind);
						errs++;
					end
					if (last !== ev.last) begin
						$error("last: expected %b, got %b", ev.last, last);
						errs++;
					end
				end
			end
			if (in_valid && in_ready)
				apply_timer_op(op, timer_id, timeout);
			mismatch_count     <= mismatch_count + errs;
			events_outstanding <= expected_events.size();
		end
	end

endmodule

### tb/tb_timer_table_expiry.sv
// Testbench top for timer_table_expiry: drives directed and random
// operations under several idle patterns and gives the verdict.
// Depends on tte_pkg, timer_table_expiry and tte_event_checker.
`timescale 1ns / 1ps

module tb_timer_table_expiry
	import tte_pkg::*;
();

	// Worst tick is one search pass per due entry plus receiver stalls; the
	// whole run stays far below this.
	localparam int CYCLE_LIMIT = 1_000_000;
	// An add or kill keeps the block busy after its last result.
	localparam int TAIL_CYCLES = 400;
	// The unused fourth operation code, which the block must ignore.
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int POOL_SIZE = 24;
	localparam logic [ID_W-1:0] FILL_BASE = 32'h8000_0000;
	localparam logic [ID_W-1:0] FULL_ID   = 32'h1234_5678;

	logic             clk       = 1'b0;
	logic             arst_n    = 1'b0;
	logic             in_valid  = 1'b0;
	logic [1:0]       op        = OP_TICK;
	logic [ID_W-1:0]  timer_id  = '0;
	logic [REM_W-1:0] timeout   = '0;
	logic             out_ready = 1'b0;

	logic             in_ready;
	logic             out_valid;
	logic [ID_W-1:0]  event_id;
	logic             kind;
	logic             last;

	int mismatch_count;
	int events_outstanding;

	// Percent of cycles in which the sender holds off and the receiver stalls.
	int in_idle_pct   = 0;
	int out_stall_pct = 0;

	// Ids reused by adds and kills so that duplicates and hits are common.
	logic [ID_W-1:0] id_pool [POOL_SIZE];

	timer_table_expiry i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.timer_id  (timer_id),
		.timeout   (timeout),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.event_id  (event_id),
		.kind      (kind),
		.last      (last)
	);

	tte_event_checker i_checker (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_ready           (in_ready),
		.op                 (op),
		.timer_id           (timer_id),
		.timeout            (timeout),
		.out_valid          (out_valid),
		.out_ready          (out_ready),
		.event_id           (event_id),
		.kind               (kind),
		.last               (last),
		.mismatch_count     (mismatch_count),
		.events_outstanding (events_outstanding)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Stall the result channel at random, one decision per cycle.
	always @(posedge clk) begin
		out_ready <= ($urandom_range(99) >= out_stall_pct);
	end

	// Watchdog: end the run if the block hangs.
	initial begin
		repeat (CYCLE_LIMIT) @(posedge clk);
		$display("tb_timer_table_expiry failed");
		$finish;
	end

	// Present one operation and hold it until the transfer. Idle cycles come
	// before raising valid, never between raising it and the transfer.
	task automatic send_item(input logic [1:0] code, input logic [ID_W-1:0] id,
			input logic [REM_W-1:0] ticks);
		while ($urandom_range(99) < in_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		op       <= code;
		timer_id <= id;
		timeout  <= ticks;
		do @(posedge clk); while (!in_ready);
	endtask

	// Drop valid and hold off until every queued result has been seen.
	// The checker's count is registered behind the transfer, so let the next edge pass first.
	task automatic drain_events();
		in_valid <= 1'b0;
		@(posedge clk);
		while (events_outstanding != 0)
			@(posedge clk);
	endtask

	// Random operations, mostly on pooled ids; the unused code is noise and
	// does not count toward the phase.
	task automatic run_random(input int items);
		int done;
		int r;
		int t;
		logic [ID_W-1:0]  id;
		logic [REM_W-1:0] ticks;
		done = 0;
		while (done < items) begin
			r  = $urandom_range(99);
			id = ($urandom_range(99) < 85) ? id_pool[$urandom_range(POOL_SIZE - 1)]
				: ID_W'($urandom);
			t = $urandom_range(99);
			if (t < 70)
				ticks = REM_W'($urandom_range(8));
			else if (t < 90)
				ticks = REM_W'($urandom_range(40, 9));
			else
				ticks = REM_W'($urandom_range(65535));
			if (r < 35) begin
				send_item(OP_TICK, ID_W'($urandom), REM_W'($urandom_range(65535)));
				done++;
			end else if (r < 75) begin
				send_item(OP_ADD, id, ticks);
				done++;
			end else if (r < 95) begin
				send_item(OP_KILL, id, REM_W'($urandom_range(65535)));
				done++;
			end else begin
				send_item(OP_UNUSED, ID_W'($urandom), REM_W'($urandom_range(65535)));
			end
		end
	endtask

	initial begin
		id_pool[0] = '0;
		id_pool[1] = '1;
		for (int i = 2; i < POOL_SIZE; i++)
			id_pool[i] = ID_W'($urandom);

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, no idling on either side.
		send_item(OP_TICK, '1, '1);          // tick on an empty table
		send_item(OP_UNUSED, '1, '1);        // unknown code, ignored
		send_item(OP_ADD, '0, '0);           // timeout zero expires next tick
		send_item(OP_ADD, '1, 16'd1);
		send_item(OP_ADD, '0, '1);           // duplicate id, old deadline stays
		send_item(OP_KILL, 32'd7, '1);       // kill of an absent id
		send_item(OP_TICK, '0, '0);          // both due, lowest id first
		drain_events();

		// Fill every slot with descending ids so the report must reorder them.
		for (int i = 0; i < TABLE_ENTRIES; i++)
			send_item(OP_ADD, FILL_BASE + ID_W'((TABLE_ENTRIES - 1 - i) * 7), 16'd1);
		send_item(OP_ADD, FULL_ID, 16'd5);   // table full, rejected
		send_item(OP_KILL, FILL_BASE + ID_W'((TABLE_ENTRIES - 5) * 7), '1);
		send_item(OP_ADD, FULL_ID, '0);      // takes the freed slot
		send_item(OP_TICK, '1, '1);          // every slot due at once
		drain_events();

		// Random phases: free running, sender idle, receiver stalling, both.
		in_idle_pct   = 0;
		out_stall_pct = 0;
		run_random(36);
		drain_events();

		in_idle_pct   = 63;
		out_stall_pct = 0;
		run_random(36);
		drain_events();

		in_idle_pct   = 0;
		out_stall_pct = 63;
		run_random(36);
		drain_events();

		in_idle_pct   = 30;
		out_stall_pct = 30;
		run_random(35);
		drain_events();

		// Let the last operation finish; any stray result counts as a mismatch.
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatch_count == 0 && events_outstanding == 0) begin
			$display("tb_timer_table_expiry passed");
		end else begin
			$display("tb_timer_table_expiry failed");
		end
		$finish;
	end

endmodule
